// ===== rtl/core/brlt_pkg.sv =====
// brlt_pkg: shared types, codes and sizes for the byte-range lock table.
// Used by byte_range_lock_table_core and its port checker.
package brlt_pkg;

  localparam int TableDepthDef = 256;
  localparam int KeyBitsDef    = 32;
  localparam int OffBits       = 63;
  localparam int PidBits       = 16;
  localparam logic [OffBits-1:0] MaxOffset = {OffBits{1'b1}};

  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    LT_READ   = 2'd0,
    LT_WRITE  = 2'd1,
    LT_UNLOCK = 2'd2,
    LT_RSVD   = 2'd3
  } lock_type_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CONF = 2'd1,
    ST_WAIT = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,   // conflict search (set, query)
    S_CLEAR,  // clear own overlaps / release
    S_ALLOC,  // find first free slot
    S_DONE
  } fsm_t;

  // saturating end of [s, s+l), zero length meaning to end of file
  function automatic logic [OffBits-1:0] range_end(input logic [OffBits-1:0] s,
                                                   input logic [OffBits-1:0] l);
    logic [OffBits:0] e;
    e = {1'b0, s} + {1'b0, l};
    if (l == '0 || e[OffBits]) range_end = MaxOffset;
    else range_end = e[OffBits-1:0];
  endfunction

endpackage

// ===== rtl/core/byte_range_lock_table_core.sv =====
// byte_range_lock_table_core: byte-range lock table with memory-held entries.
// Depends on brlt_pkg.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | cmd, file_key, pid, lock_type, range_start/len, may_wait
//  out_    | out | out_valid/out_stall| status, holder_*, wake_waiters
//
// One transaction at a time. Each scan reads one slot a cycle from the entry
// memory, which has a registered read. Set runs a conflict scan, a clear scan,
// an allocate step and a result step; a conflict found in the first scan ends
// it early and goes straight to the result step. Query, unlock and release
// take one scan, then the result step; a no-op goes straight to the result.
// Valid bits sit in flip-flops and are cleared by reset at once, so no clearing
// pass. in_stall is high while busy or while a result waits under out_stall.
module byte_range_lock_table_core #(
  parameter int TABLE_DEPTH = brlt_pkg::TableDepthDef,
  parameter int KEY_BITS    = brlt_pkg::KeyBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_file_key,
  input  logic [15:0] in_pid,
  input  logic [1:0]  in_lock_type,
  input  logic [62:0] in_range_start,
  input  logic [62:0] in_range_len,
  input  logic        in_may_wait,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_holder_pid,
  output logic        out_holder_write,
  output logic [62:0] out_holder_start,
  output logic [62:0] out_holder_len,
  output logic        out_wake_waiters
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = KEY_BITS + 16 + 1 + 63 + 63;
  localparam logic [CW-1:0] Last = CW'(TABLE_DEPTH - 1);

  // entry memory {key, owner, write, start, len}
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_q;
  logic [TABLE_DEPTH-1:0] vld_r, vld_nxt;

  brlt_pkg::fsm_t st_r, st_nxt;
  logic [CW-1:0] idx_r, idx_nxt;    // address being issued
  logic          rdv_r, rdv_nxt;    // read data valid for slot rdi_r
  logic [IW-1:0] rdi_r, rdi_nxt;

  logic [1:0]  cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [15:0] pid_r;
  logic        wr_r, unl_r, wait_r;
  logic [62:0] s_r, l_r, e_r;

  logic        any_r, any_nxt;
  logic        we;
  logic [IW-1:0] wa;

  logic        ov_r, ov_nxt;
  logic [1:0]  st_o_r, st_o_nxt;
  logic [15:0] hp_r, hp_nxt;
  logic        hw_r, hw_nxt, wk_r, wk_nxt;
  logic [62:0] hs_r, hs_nxt, hl_r, hl_nxt;

  // decoded read slot
  logic [KEY_BITS-1:0] m_key;
  logic [15:0] m_own;
  logic        m_wr;
  logic [62:0] m_s, m_l;
  logic        m_v, m_ovl, m_conf, m_mine;

  assign {m_key, m_own, m_wr, m_s, m_l} = rd_q;
  assign m_v   = rdv_r & vld_r[rdi_r];
  assign m_ovl = (m_s < e_r) && (s_r < brlt_pkg::range_end(m_s, m_l));
  assign m_conf = m_v && m_own != pid_r && m_key == key_r && m_ovl && (wr_r || m_wr);
  assign m_mine = m_v && m_own == pid_r && m_key == key_r && m_ovl;

  wire accept = in_valid && !in_stall;
  assign in_stall  = (st_r != brlt_pkg::S_IDLE) || (ov_r && out_stall);
  assign out_valid = ov_r;
  assign out_status = st_o_r;
  assign out_holder_pid = hp_r;
  assign out_holder_write = hw_r;
  assign out_holder_start = hs_r;
  assign out_holder_len = hl_r;
  assign out_wake_waiters = wk_r;

  // entry memory: synchronous read, one write port
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= {key_r, pid_r, wr_r, s_r, l_r};
    rd_q <= mem[idx_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      key_r  <= KEY_BITS'(in_file_key);
      pid_r  <= in_pid;
      wr_r   <= (in_lock_type == brlt_pkg::LT_WRITE);
      unl_r  <= in_lock_type[1];
      wait_r <= in_may_wait;
      s_r    <= in_range_start;
      l_r    <= in_range_len;
      e_r    <= brlt_pkg::range_end(in_range_start, in_range_len);
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      brlt_pkg::S_IDLE:
        if (accept) begin
          unique case (in_cmd)
            brlt_pkg::CMD_SET:
              st_nxt = in_lock_type[1] ? brlt_pkg::S_CLEAR : brlt_pkg::S_SCAN;
            brlt_pkg::CMD_QUERY:   st_nxt = brlt_pkg::S_SCAN;
            brlt_pkg::CMD_RELEASE: st_nxt = brlt_pkg::S_CLEAR;
            default:               st_nxt = brlt_pkg::S_DONE;
          endcase
        end
      brlt_pkg::S_SCAN:
        if (m_conf) st_nxt = brlt_pkg::S_DONE;
        else if (rdv_r && rdi_r == Last[IW-1:0])
          st_nxt = (cmd_r == brlt_pkg::CMD_QUERY) ? brlt_pkg::S_DONE : brlt_pkg::S_CLEAR;
      brlt_pkg::S_CLEAR:
        if (rdv_r && rdi_r == Last[IW-1:0])
          st_nxt = (cmd_r == brlt_pkg::CMD_SET && !unl_r) ? brlt_pkg::S_ALLOC
                                                           : brlt_pkg::S_DONE;
      brlt_pkg::S_ALLOC: st_nxt = brlt_pkg::S_DONE;
      brlt_pkg::S_DONE:  st_nxt = brlt_pkg::S_IDLE;
      default:           st_nxt = brlt_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt = idx_r;
    rdv_nxt = 1'b0;
    rdi_nxt = rdi_r;
    vld_nxt = vld_r;
    any_nxt = any_r;
    we = 1'b0;
    wa = '0;
    ov_nxt = ov_r && out_stall;
    st_o_nxt = st_o_r; hp_nxt = hp_r; hw_nxt = hw_r;
    hs_nxt = hs_r; hl_nxt = hl_r; wk_nxt = wk_r;
    unique case (st_r)
      brlt_pkg::S_IDLE: begin
        idx_nxt = '0;
        any_nxt = 1'b0;
        st_o_nxt = brlt_pkg::ST_OK;
        hp_nxt = '0; hw_nxt = 1'b0; hs_nxt = '0; hl_nxt = '0; wk_nxt = 1'b0;
        if (!accept) begin
          st_o_nxt = st_o_r; hp_nxt = hp_r; hw_nxt = hw_r;
          hs_nxt = hs_r; hl_nxt = hl_r; wk_nxt = wk_r;
        end
      end
      brlt_pkg::S_SCAN, brlt_pkg::S_CLEAR: begin
        if (idx_r <= Last) begin
          rdv_nxt = 1'b1;
          rdi_nxt = idx_r[IW-1:0];
          idx_nxt = idx_r + 1'b1;
        end
        if (st_r == brlt_pkg::S_SCAN) begin
          if (m_conf) begin
            if (cmd_r == brlt_pkg::CMD_QUERY) begin
              st_o_nxt = brlt_pkg::ST_CONF;
              hp_nxt = m_own; hw_nxt = m_wr; hs_nxt = m_s; hl_nxt = m_l;
            end else begin
              st_o_nxt = wait_r ? brlt_pkg::ST_WAIT : brlt_pkg::ST_CONF;
            end
          end else if (rdv_r && rdi_r == Last[IW-1:0]) begin
            idx_nxt = '0;
            rdv_nxt = 1'b0;
          end
        end else begin
          if (cmd_r == brlt_pkg::CMD_RELEASE) begin
            if (m_v && m_own == pid_r) begin
              vld_nxt[rdi_r] = 1'b0;
              any_nxt = 1'b1;
            end
          end else if (m_mine) begin
            vld_nxt[rdi_r] = 1'b0;
          end
          if (rdv_r && rdi_r == Last[IW-1:0]) begin
            rdv_nxt = 1'b0;
            if (cmd_r == brlt_pkg::CMD_RELEASE) wk_nxt = any_nxt;
            else if (unl_r) wk_nxt = 1'b1;
          end
        end
      end
      brlt_pkg::S_ALLOC: begin
        // lowest free slot from the valid bits
        st_o_nxt = brlt_pkg::ST_FULL;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
          if (!vld_r[i]) begin
            st_o_nxt = brlt_pkg::ST_OK;
            wa = IW'(i);
          end
        end
        if (st_o_nxt == brlt_pkg::ST_OK) begin
          we = 1'b1;
          vld_nxt[wa] = 1'b1;
        end
      end
      brlt_pkg::S_DONE: ov_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= brlt_pkg::S_IDLE;
      vld_r <= '0;
      rdv_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      vld_r <= vld_nxt;
      rdv_r <= rdv_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    rdi_r <= rdi_nxt;
    any_r <= any_nxt;
    st_o_r <= st_o_nxt;
    hp_r <= hp_nxt; hw_r <= hw_nxt; hs_r <= hs_nxt; hl_r <= hl_nxt;
    wk_r <= wk_nxt;
  end

endmodule

// ===== rtl/core/brlt_checker.sv =====
// brlt_checker: port-level assertions for byte_range_lock_table_core.
// Depends on brlt_pkg; bound to byte_range_lock_table_core below.
module brlt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [15:0] out_holder_pid,
  input logic        out_wake_waiters
);

  // one transaction at a time: no new input while a result waits under stall
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled result changed");

  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake_waiters |-> out_status == brlt_pkg::ST_OK)
    else $error("wake with non-ok status");

  // holder fields only carry data on a found query
  a_holder: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != brlt_pkg::ST_CONF |-> out_holder_pid == '0)
    else $error("holder pid outside a found query");

  a_after_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind byte_range_lock_table_core brlt_checker u_brlt_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_holder_pid(out_holder_pid), .out_wake_waiters(out_wake_waiters)
);

// ===== bench/tb_byte_range_lock_table_core.sv =====
// Testbench for byte_range_lock_table_core: directed and random lock traffic,
// results checked against a behavioural lock table kept in the bench.
// Depends on brlt_pkg and byte_range_lock_table_core.
module tb_byte_range_lock_table_core;
  import brlt_pkg::*;

  localparam int Depth = TableDepthDef;

  typedef struct {
    cmd_t             cmd;
    logic [31:0]      key;
    logic [15:0]      pid;
    lock_type_t       ltype;
    logic [62:0]      start;
    logic [62:0]      len;
    logic             may_wait;
  } lock_req_t;

  typedef struct {
    status_t          status;
    logic [15:0]      hpid;
    logic             hwrite;
    logic [62:0]      hstart;
    logic [62:0]      hlen;
    logic             wake;
  } lock_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic [31:0] in_file_key = '0;
  logic [15:0] in_pid = '0;
  logic [1:0] in_lock_type = '0;
  logic [62:0] in_range_start = '0;
  logic [62:0] in_range_len = '0;
  logic in_may_wait = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [15:0] out_holder_pid;
  logic out_holder_write;
  logic [62:0] out_holder_start;
  logic [62:0] out_holder_len;
  logic out_wake_waiters;

  byte_range_lock_table_core u_dut (.*);

  always #5 clk = ~clk;

  // lock table shadow
  logic        tbl_valid [Depth];
  logic [31:0] tbl_key   [Depth];
  logic [15:0] tbl_owner [Depth];
  logic        tbl_write [Depth];
  logic [62:0] tbl_start [Depth];
  logic [62:0] tbl_len   [Depth];

  lock_req_t  pending_reqs[$];
  lock_resp_t expected_resps[$];
  int errors = 0;
  bit hold_sender = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic logic [62:0] sat_end(logic [62:0] s, logic [62:0] l);
    logic [63:0] e;
    e = {1'b0, s} + {1'b0, l};
    if (l == '0 || e > {1'b0, MaxOffset}) return MaxOffset;
    return e[62:0];
  endfunction

  function automatic bit ranges_meet(int i, logic [62:0] s, logic [62:0] l);
    return tbl_start[i] < sat_end(s, l) && s < sat_end(tbl_start[i], tbl_len[i]);
  endfunction

  function automatic int first_conflict(lock_req_t r, bit wr);
    for (int i = 0; i < Depth; i++)
      if (tbl_valid[i] && tbl_owner[i] != r.pid && tbl_key[i] == r.key &&
          ranges_meet(i, r.start, r.len) && (wr || tbl_write[i]))
        return i;
    return -1;
  endfunction

  function automatic lock_resp_t apply_lock_req(lock_req_t r);
    lock_resp_t o;
    bit wr;
    bit unl;
    bit any;
    int c;
    o = '{ST_OK, '0, 1'b0, '0, '0, 1'b0};
    wr = (r.ltype == LT_WRITE);
    unl = (r.ltype == LT_UNLOCK || r.ltype == LT_RSVD);
    case (r.cmd)
      CMD_SET: begin
        if (!unl && first_conflict(r, wr) >= 0) begin
          o.status = r.may_wait ? ST_WAIT : ST_CONF;
          return o;
        end
        for (int i = 0; i < Depth; i++)
          if (tbl_valid[i] && tbl_owner[i] == r.pid && tbl_key[i] == r.key &&
              ranges_meet(i, r.start, r.len))
            tbl_valid[i] = 1'b0;
        if (unl) begin
          o.wake = 1'b1;
          return o;
        end
        for (int i = 0; i < Depth; i++)
          if (!tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_key[i] = r.key;
            tbl_owner[i] = r.pid;
            tbl_write[i] = wr;
            tbl_start[i] = r.start;
            tbl_len[i] = r.len;
            return o;
          end
        o.status = ST_FULL;
      end
      CMD_QUERY: begin
        c = first_conflict(r, wr);
        if (c >= 0) begin
          o.status = ST_CONF;
          o.hpid = tbl_owner[c];
          o.hwrite = tbl_write[c];
          o.hstart = tbl_start[c];
          o.hlen = tbl_len[c];
        end
      end
      CMD_RELEASE: begin
        any = 1'b0;
        for (int i = 0; i < Depth; i++)
          if (tbl_valid[i] && tbl_owner[i] == r.pid) begin
            tbl_valid[i] = 1'b0;
            any = 1'b1;
          end
        o.wake = any;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic lock_req_t mk(cmd_t c, logic [31:0] k, logic [15:0] p,
                                   lock_type_t t, logic [62:0] s, logic [62:0] l,
                                   logic w);
    lock_req_t r;
    r = '{c, k, p, t, s, l, w};
    return r;
  endfunction

  // mostly small keys, pids and offsets so that locks meet often
  function automatic lock_req_t rand_req();
    lock_req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r.cmd = sel < 70 ? CMD_SET : sel < 88 ? CMD_QUERY : sel < 97 ? CMD_RELEASE : CMD_NOP;
    r.key = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 3));
    r.pid = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 6));
    r.ltype = lock_type_t'($urandom_range(0, 9) < 7 ? $urandom_range(0, 1)
                                                     : $urandom_range(2, 3));
    if ($urandom_range(0, 9) == 0) begin
      r.start = 63'({$urandom(), $urandom()});
      r.len = 63'({$urandom(), $urandom()});
    end else begin
      r.start = 63'($urandom_range(0, 200));
      r.len = ($urandom_range(0, 7) == 0) ? '0 : 63'($urandom_range(1, 60));
    end
    r.may_wait = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_sender) begin
        lock_req_t r;
        r = pending_reqs.pop_front();
        expected_resps.push_back(apply_lock_req(r));
        in_cmd <= r.cmd;
        in_file_key <= r.key;
        in_pid <= r.pid;
        in_lock_type <= r.ltype;
        in_range_start <= r.start;
        in_range_len <= r.len;
        in_may_wait <= r.may_wait;
        in_valid <= 1'b1;
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_resps.size() == 0) begin
          report_mismatch("unexpected transaction", 64'd1, 64'd0);
        end else begin
          lock_resp_t e;
          e = expected_resps.pop_front();
          if (out_status != e.status) report_mismatch("status", out_status, e.status);
          if (out_holder_pid != e.hpid) report_mismatch("holder_pid", out_holder_pid, e.hpid);
          if (out_holder_write != e.hwrite)
            report_mismatch("holder_write", out_holder_write, e.hwrite);
          if (out_holder_start != e.hstart)
            report_mismatch("holder_start", out_holder_start, e.hstart);
          if (out_holder_len != e.hlen) report_mismatch("holder_len", out_holder_len, e.hlen);
          if (out_wake_waiters != e.wake)
            report_mismatch("wake_waiters", out_wake_waiters, e.wake);
        end
        recv_gap <= $urandom_range(0, 3);
        out_stall <= ($urandom_range(0, 3) != 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    for (int i = 0; i < Depth; i++) tbl_valid[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, every command and lock type
    pending_reqs.push_back(mk(CMD_SET, 32'hffff_ffff, 16'hffff, LT_WRITE, MaxOffset, MaxOffset,
                              1'b0));
    pending_reqs.push_back(mk(CMD_SET, 32'hffff_ffff, 16'h0000, LT_READ, '0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_SET, 32'hffff_ffff, 16'h0000, LT_READ, '0, '0, 1'b1));
    pending_reqs.push_back(mk(CMD_QUERY, 32'hffff_ffff, 16'h0000, LT_UNLOCK, '0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_SET, 32'd0, 16'd1, LT_READ, 63'd10, 63'd10, 1'b0));
    pending_reqs.push_back(mk(CMD_SET, 32'd0, 16'd2, LT_READ, 63'd15, 63'd10, 1'b0));
    pending_reqs.push_back(mk(CMD_QUERY, 32'd0, 16'd3, LT_WRITE, 63'd19, 63'd1, 1'b0));
    pending_reqs.push_back(mk(CMD_QUERY, 32'd0, 16'd3, LT_READ, 63'd0, 63'd100, 1'b0));
    pending_reqs.push_back(mk(CMD_SET, 32'd0, 16'd3, LT_WRITE, 63'd20, 63'd5, 1'b1));
    pending_reqs.push_back(mk(CMD_SET, 32'd0, 16'd3, LT_WRITE, 63'd25, 63'd5, 1'b0));
    pending_reqs.push_back(mk(CMD_SET, 32'd0, 16'd1, LT_RSVD, 63'd0, 63'd0, 1'b0));
    pending_reqs.push_back(mk(CMD_SET, 32'd0, 16'd2, LT_UNLOCK, 63'd15, 63'd1, 1'b0));
    pending_reqs.push_back(mk(CMD_SET, 32'd1, 16'd4, LT_WRITE, MaxOffset - 63'd3, 63'd100,
                              1'b0));
    pending_reqs.push_back(mk(CMD_QUERY, 32'd1, 16'd5, LT_READ, MaxOffset - 63'd1, 63'd1,
                              1'b0));
    pending_reqs.push_back(mk(CMD_NOP, 32'hffff_ffff, 16'hffff, LT_RSVD, MaxOffset, MaxOffset,
                              1'b1));
    pending_reqs.push_back(mk(CMD_RELEASE, 32'd0, 16'd3, LT_READ, '0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_RELEASE, 32'd0, 16'd3, LT_READ, '0, '0, 1'b0));
    // fill the table to force a full report
    for (int i = 0; i < Depth + 2; i++)
      pending_reqs.push_back(mk(CMD_SET, 32'd9, 16'd7, LT_READ, 63'(2 * i), 63'd1, 1'b0));
    pending_reqs.push_back(mk(CMD_RELEASE, 32'd0, 16'd7, LT_READ, '0, '0, 1'b0));
    wait (pending_reqs.size() == 0);
    // let everything drain once before the random part
    hold_sender = 1'b1;
    wait (expected_resps.size() == 0);
    hold_sender = 1'b0;
    for (int n = 0; n < 720; n++) begin
      pending_reqs.push_back(rand_req());
      if (n % 100 == 99) wait (pending_reqs.size() < 20);
    end
    wait (pending_reqs.size() == 0);
    wait (expected_resps.size() == 0);
    repeat (1000) @(posedge clk);
    if (errors == 0) $display("[byte_range_lock_table_core] OK");
    else $display("[byte_range_lock_table_core] ERROR");
    $finish;
  end

  initial begin
    #40000000;
    $display("[byte_range_lock_table_core] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/brlt_pkg.sv
rtl/core/byte_range_lock_table_core.sv
rtl/core/brlt_checker.sv
bench/tb_byte_range_lock_table_core.sv
